// File: rtl/core/sitda_pkg.sv
package sitda_pkg;

  // Field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned DIGIT_W = 4;

  // A 32-bit magnitude never has more than ten decimal digits
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned NDIG_W     = 4;

  // ASCII codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  // Classified item: sign and unsigned magnitude
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } sitda_item_t;

  // Digits of one number, most significant at index MAX_DIGITS-1
  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] sitda_digits_t;

  typedef struct packed {
    logic               neg;
    logic [NDIG_W-1:0]  ndig;
    sitda_digits_t      digits;
  } sitda_run_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } sitda_qstat_t;

endpackage

// File: rtl/core/signed_int_to_decimal_ascii_top.sv
// Converts each signed 32-bit input beat into its decimal text, sent as one
// output beat per ASCII character, most significant first: an optional '-'
// then 1 to 10 digits without leading zeros, tlast on the final character.
// Digits are produced one per cycle by a single divide-by-ten unit
// (reciprocal multiply). A number leaves the queue, is converted digit by
// digit and is then handed over to the output stage, which holds off the
// handover while busy; conversion overlaps the output of the previous
// number. The output stage loads the next run once the previous run has
// left its buffer, and output valid drops while it is loaded unless the
// receiver is stalling. A small input queue (QUEUE_DEPTH entries) absorbs
// beats while the back end is busy.
module signed_int_to_decimal_ascii_top
  import sitda_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,    // [31:0] value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,   // [6:0] char_code, [7] zero
  output logic         out_tlast    // last_char
);

  logic         q_push, q_pop;
  sitda_item_t  push_item, head_item;
  sitda_qstat_t qstat;
  logic         run_valid, run_ready;
  sitda_run_t   run;

  sitda_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (qstat.full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  sitda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (qstat)
  );

  sitda_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .qstat     (qstat),
    .q_pop     (q_pop),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run       (run)
  );

  sitda_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .run_valid  (run_valid),
    .run_ready  (run_ready),
    .run        (run),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/core/sitda_front.sv
module sitda_front
  import sitda_pkg::*;
(
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [VALUE_W-1:0]  in_tdata,   // [31:0] value
  input  logic                q_full,
  output logic                q_push,
  output sitda_item_t         q_item
);

  // Take a beat whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Split into sign and magnitude; the most negative value wraps to 2^31
  always_comb begin
    q_item.neg = in_tdata[VALUE_W-1];
    q_item.mag = in_tdata[VALUE_W-1] ? (VALUE_W'(0) - in_tdata) : in_tdata;
  end

endmodule

// File: rtl/core/sitda_queue.sv
module sitda_queue
  import sitda_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  sitda_item_t  push_item,
  input  logic         pop,
  output sitda_item_t  head_item,
  output sitda_qstat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sitda_item_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == CNT_W'(0));
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/sitda_conv.sv
module sitda_conv
  import sitda_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  sitda_item_t  head_item,
  input  sitda_qstat_t qstat,
  output logic         q_pop,
  output logic         run_valid,
  input  logic         run_ready,
  output sitda_run_t   run
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } conv_state_t;

  conv_state_t          state_r, state_nxt;
  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [NDIG_W-1:0]    ndig_r, ndig_nxt;
  sitda_digits_t        dig_r, dig_nxt;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   diff;
  logic [DIGIT_W-1:0]   rem;

  // Divide by ten through the reciprocal, remainder by shift-add
  assign prod     = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  assign quot_x10 = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
  assign diff     = mag_r - quot_x10;
  assign rem      = diff[DIGIT_W-1:0];

  assign q_pop     = (state_r == ST_IDLE) && !qstat.empty;
  assign run_valid = (state_r == ST_DONE);
  assign run.neg    = neg_r;
  assign run.ndig   = ndig_r;
  assign run.digits = dig_r;

  // One digit per cycle, least significant first, shifted in at the top
  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    ndig_nxt  = ndig_r;
    dig_nxt   = dig_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          mag_nxt   = head_item.mag;
          neg_nxt   = head_item.neg;
          ndig_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          dig_nxt[i] = dig_r[i+1];
        end
        dig_nxt[MAX_DIGITS-1] = rem;
        ndig_nxt = ndig_r + NDIG_W'(1);
        mag_nxt  = quot;
        if (quot == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (run_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    ndig_r <= ndig_nxt;
    dig_r  <= dig_nxt;
  end

endmodule

// File: rtl/core/sitda_emit.sv
module sitda_emit
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        run_valid,
  output logic        run_ready,
  input  sitda_run_t  run,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [6:0] char_code, [7] zero
  output logic        out_tlast    // last_char
);

  logic                neg_pend_r, neg_pend_nxt;
  logic [NDIG_W-1:0]   left_r, left_nxt;
  sitda_digits_t       dig_r, dig_nxt;
  logic                valid_r, valid_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                last_r, last_nxt;
  logic                busy, adv;

  assign busy      = neg_pend_r || (left_r != '0);
  assign adv       = !valid_r || out_tready;
  assign run_ready = !busy;

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, char_r};
  assign out_tlast  = last_r;

  // Sign first, then digits from the top of the buffer
  always_comb begin
    neg_pend_nxt = neg_pend_r;
    left_nxt     = left_r;
    dig_nxt      = dig_r;
    valid_nxt    = valid_r;
    char_nxt     = char_r;
    last_nxt     = last_r;
    if (adv) begin
      if (neg_pend_r) begin
        valid_nxt    = 1'b1;
        char_nxt     = ASCII_MINUS;
        last_nxt     = 1'b0;
        neg_pend_nxt = 1'b0;
      end else if (left_r != '0) begin
        valid_nxt = 1'b1;
        char_nxt  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig_r[MAX_DIGITS-1]};
        last_nxt  = (left_r == NDIG_W'(1));
        for (int i = MAX_DIGITS - 1; i > 0; i--) begin
          dig_nxt[i] = dig_r[i-1];
        end
        dig_nxt[0] = '0;
        left_nxt   = left_r - NDIG_W'(1);
      end else begin
        valid_nxt = 1'b0;
      end
    end
    // Load the next number once the previous one has left the buffer
    if (run_valid && !busy) begin
      neg_pend_nxt = run.neg;
      left_nxt     = run.ndig;
      dig_nxt      = run.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_pend_r <= 1'b0;
      left_r     <= '0;
      valid_r    <= 1'b0;
    end else begin
      neg_pend_r <= neg_pend_nxt;
      left_r     <= left_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

// File: rtl/core/sitda_chk.sv
module sitda_chk
  import sitda_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // Only a minus sign or a digit ever goes out
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7] &&
                   ((out_tdata[CHAR_W-1:0] == ASCII_MINUS) ||
                    ((out_tdata[CHAR_W-1:0] >= ASCII_ZERO) &&
                     (out_tdata[CHAR_W-1:0] <= ASCII_ZERO + CHAR_W'(9)))))
    else $error("character outside sign and digit set");

  // A sign is always followed by digits
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == {1'b0, ASCII_MINUS}) |-> !out_tlast)
    else $error("minus sign flagged as last");

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_top sitda_chk u_sitda_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: tb/decimal_text_checker.sv
// Watches both streams of the decimal text converter, predicts the ASCII run
// for every accepted input beat and compares each output beat against it.
module decimal_text_checker
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [7:0]         out_tdata,
  input  logic               out_tlast,
  output int unsigned        mismatch_count,
  output int unsigned        chars_due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RADIX       = 10;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t chars_due[$];

  // Expected characters of one number: optional minus, then digits MS first
  function automatic void spell_decimal(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digit_lsf [MAX_DIGITS];
    int                 ndig;
    text_char_t         ch;
    mag  = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
    ndig = 0;
    // zero still yields one digit
    do begin
      digit_lsf[ndig] = DIGIT_W'(mag % RADIX);
      mag             = mag / RADIX;
      ndig++;
    end while (mag != 0 && ndig < MAX_DIGITS);
    if (value[VALUE_W-1]) begin
      ch.code = ASCII_MINUS;
      ch.last = 1'b0;
      chars_due.push_back(ch);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.code = ASCII_ZERO + CHAR_W'(digit_lsf[k]);
      ch.last = (k == 0);
      chars_due.push_back(ch);
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0t] %s", $realtime, what);
  endfunction

  // Both channels sampled at the rising edge
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        spell_decimal(in_tdata);
      if (out_tvalid && out_tready) begin
        if (chars_due.size() == 0) begin
          note_mismatch($sformatf("unexpected output beat: code %0d last %0b",
                                  out_tdata[CHAR_W-1:0], out_tlast));
        end else begin
          want = chars_due.pop_front();
          if (out_tdata[CHAR_W-1:0] !== want.code || out_tlast !== want.last ||
              out_tdata[7] !== 1'b0)
            note_mismatch($sformatf(
              "char mismatch: expected code %0d last %0b, got code %0d last %0b pad %0b",
              want.code, want.last, out_tdata[CHAR_W-1:0], out_tlast, out_tdata[7]));
        end
      end
      chars_due_count = chars_due.size();
    end
  end

endmodule

// File: tb/signed_int_to_decimal_ascii_top_tb.sv
// Stimulus and verdict for the signed integer to decimal text converter.
module signed_int_to_decimal_ascii_top_tb
  import sitda_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned BURST_ITEMS   = 8;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned N_DIRECTED    = 20;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tlast;

  int unsigned        mismatch_count;
  int unsigned        chars_due_count;
  int unsigned        cycle_count = 0;

  // Idle percentages per phase, and long hold-off requests to the receiver
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        hold_requests = 0;

  logic [VALUE_W-1:0] directed_values [N_DIRECTED] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
    -32'sd1000000000, 32'd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd100, -32'sd9, 32'd1234567890, -32'sd1234567890, 32'd99, -32'sd1
  };

  signed_int_to_decimal_ascii_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  decimal_text_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .chars_due_count (chars_due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("signed_int_to_decimal_ascii_top_tb: errors");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Random value: mostly a chosen digit count and sign, sometimes raw bits
  function automatic logic [VALUE_W-1:0] pick_value();
    longint      lo;
    longint      hi;
    int unsigned ndig;
    logic [VALUE_W-1:0] mag;
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    ndig = $urandom_range(1, MAX_DIGITS);
    lo   = 1;
    for (int k = 1; k < ndig; k++)
      lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1)
      lo = 0;
    if (hi > 64'sd2147483647)
      hi = 64'sd2147483647;
    mag = $urandom_range(int'(hi), int'(lo));
    return $urandom_range(0, 1) ? (VALUE_W'(0) - mag) : mag;
  endfunction

  // One input beat; entered and left at a falling edge
  task automatic offer_value(input logic [VALUE_W-1:0] value);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected character has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (chars_due_count != 0)
      @(negedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, zero, most negative, digit-count boundaries
    foreach (directed_values[i])
      offer_value(directed_values[i]);
    wait_drained();

    // Backpressure: receiver holds off while the sender keeps offering
    hold_requests++;
    for (int i = 0; i < BURST_ITEMS; i++)
      offer_value(pick_value());
    wait_drained();

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        offer_value(pick_value());
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("signed_int_to_decimal_ascii_top_tb: clean");
    else
      $display("signed_int_to_decimal_ascii_top_tb: errors");
    $finish;
  end

endmodule
